// ===== rtl/xcfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xcfd_pkg;

	// Result kinds carried on the output word.
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_BAD     = 2'd2;
	localparam logic [1:0] KIND_OVERRUN = 2'd3;

	// Default frame size limit and reset values.
	localparam int unsigned MAX_FRAME_DEF   = 253;
	localparam logic [7:0]  START_BYTE_RST  = 8'd254;
	localparam logic [7:0]  CHECK_SEED      = 8'd255;

	// Fixed frame layout.
	localparam logic [7:0] POS_LENGTH  = 8'd0;
	localparam logic [7:0] POS_TYPE    = 8'd4;
	localparam logic [7:0] POS_COMMAND = 8'd8;
	localparam logic [7:0] POS_PAYLOAD = 8'd9;
	localparam logic [7:0] HEADER_LEN  = 8'd10;

endpackage

`default_nettype wire

// ===== rtl/xor_checked_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Signals                                   | Direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_stall, rx_byte               | byte in
// out     | out_valid, out_stall, kind, data_byte,    | word out
//         | msg_type, command_code, payload_length,   |
//         | last                                      |
// cfg     | cfg_we, cfg_wdata (start byte)            | write only
//
// One received byte is taken every cycle while in_stall is low. An accepted
// byte is held in the input register and decoded into the output register
// once that register is free or drains.
// The asynchronous reset returns the block to hunting with start byte 254.
// While the output word is held by out_stall, the input register stops and
// in_stall rises once it is occupied.

module xor_checked_frame_deframer_unit #(
	parameter int unsigned MAX_FRAME = xcfd_pkg::MAX_FRAME_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire  [7:0] cfg_wdata,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] rx_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] msg_type,
	output logic [7:0] command_code,
	output logic [7:0] payload_length,
	output logic       last
);
	import xcfd_pkg::*;

	localparam logic [8:0] MAX_POS = 9'(MAX_FRAME);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [7:0] start_byte_q;
	logic       in_frame_q;
	logic [7:0] pos_q;
	logic [7:0] check_q;
	logic [7:0] len_q;
	logic [7:0] type_q;
	logic [7:0] cmd_q;

	logic       advance;
	logic       fire;
	logic       is_check_pos;
	logic [8:0] next_pos;
	logic [7:0] check_nxt;
	logic [7:0] len_nxt;
	logic [7:0] type_nxt;
	logic [7:0] cmd_nxt;
	logic       res_valid;
	logic [1:0] res_kind;
	logic [7:0] res_data;
	logic [7:0] res_plen;
	logic       res_last;

	// The decode stage moves whenever the output register is free or drains.
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
		end else if (cfg_we) begin
			start_byte_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame decode of the byte in the input register.
	always_comb begin
		is_check_pos = (pos_q != 8'd0) && (len_q > POS_PAYLOAD) &&
			(pos_q == len_q - 8'd1);
		next_pos  = {1'b0, pos_q} + 9'd1;
		check_nxt = check_q ^ byte_s1;
		len_nxt   = (pos_q == POS_LENGTH)  ? byte_s1 : len_q;
		type_nxt  = (pos_q == POS_TYPE)    ? byte_s1 : type_q;
		cmd_nxt   = (pos_q == POS_COMMAND) ? byte_s1 : cmd_q;
		res_valid = 1'b0;
		res_kind  = KIND_PAYLOAD;
		res_data  = 8'd0;
		res_plen  = 8'd0;
		res_last  = 1'b0;
		if (in_frame_q) begin
			if (is_check_pos) begin
				res_valid = 1'b1;
				res_kind  = (byte_s1 == check_q) ? KIND_GOOD : KIND_BAD;
				res_plen  = len_q - HEADER_LEN;
				res_last  = 1'b1;
			end else if (next_pos >= MAX_POS) begin
				res_valid = 1'b1;
				res_kind  = KIND_OVERRUN;
				res_last  = 1'b1;
			end else if (pos_q >= POS_PAYLOAD) begin
				res_valid = 1'b1;
				res_data  = byte_s1;
			end
		end
	end

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= 8'd0;
			check_q    <= CHECK_SEED;
			len_q      <= 8'd0;
			type_q     <= 8'd0;
			cmd_q      <= 8'd0;
		end else if (fire) begin
			if (!in_frame_q) begin
				if (byte_s1 == start_byte_q) begin
					in_frame_q <= 1'b1;
					pos_q      <= 8'd0;
					check_q    <= CHECK_SEED;
				end
			end else if (is_check_pos) begin
				in_frame_q <= 1'b0;
				pos_q      <= 8'd0;
				len_q      <= 8'd0;
			end else begin
				check_q <= check_nxt;
				type_q  <= type_nxt;
				cmd_q   <= cmd_nxt;
				if (next_pos >= MAX_POS) begin
					in_frame_q <= 1'b0;
					pos_q      <= 8'd0;
					len_q      <= 8'd0;
				end else begin
					pos_q <= next_pos[7:0];
					len_q <= len_nxt;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			kind           <= res_kind;
			data_byte      <= res_data;
			msg_type       <= (in_frame_q && !is_check_pos) ? type_nxt : type_q;
			command_code   <= (in_frame_q && !is_check_pos) ? cmd_nxt : cmd_q;
			payload_length <= res_plen;
			last           <= res_last;
		end
	end

	// A word that does not end a frame is always a payload byte.
	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> kind == KIND_PAYLOAD && payload_length == 8'd0)
		else $error("non-final word is not a clean payload byte");

	// A frame-ending word on the output means the decoder is hunting again.
	a_end_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !in_frame_q)
		else $error("frame end reported while still inside a frame");

	// The position never reaches the frame limit.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < MAX_POS)
		else $error("frame position past limit");

	// Leaving a frame always clears the position and length.
	a_exit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_frame_q) |-> pos_q == 8'd0 && len_q == 8'd0)
		else $error("frame state not cleared at frame end");

endmodule

`default_nettype wire

// ===== test/xcfd_frame_checker.sv =====
`timescale 1ns / 1ps

// Watches the byte, word and configuration channels of the deframer. It keeps
// its own copy of the frame state, predicts the words each accepted byte
// causes, and checks every accepted output word against the oldest prediction.
module xcfd_frame_checker #(
	parameter int unsigned MAX_FRAME = xcfd_pkg::MAX_FRAME_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       cfg_we,
	input  wire [7:0] cfg_wdata,
	input  wire       in_valid,
	input  wire       in_stall,
	input  wire [7:0] rx_byte,
	input  wire       out_valid,
	input  wire       out_stall,
	input  wire [1:0] kind,
	input  wire [7:0] data_byte,
	input  wire [7:0] msg_type,
	input  wire [7:0] command_code,
	input  wire [7:0] payload_length,
	input  wire       last,
	output int        errors,
	output int        pending
);

	import xcfd_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [7:0] mtype;
		logic [7:0] cmd;
		logic [7:0] plen;
		logic       last;
	} frame_word_t;

	// Words predicted but not yet seen on the output channel.
	frame_word_t expected_words[$];

	// Predicted frame state.
	logic [7:0] start_reg;
	logic       in_frame;
	logic [7:0] pos_reg;
	logic [7:0] check_reg;
	logic [7:0] length_reg;
	logic [7:0] type_reg;
	logic [7:0] command_reg;

	// Queue one predicted word, carrying the captured type and command.
	task automatic push_word(input logic [1:0] k, input logic [7:0] d, input logic [7:0] pl,
			input logic l);
		frame_word_t w;
		w.kind = k;
		w.data = d;
		w.mtype = type_reg;
		w.cmd = command_reg;
		w.plen = pl;
		w.last = l;
		expected_words.push_back(w);
		pending++;
	endtask

	// Leave the frame and go back to hunting for the start byte.
	task automatic close_frame();
		in_frame = 1'b0;
		pos_reg = '0;
		length_reg = '0;
	endtask

	// Advance the predicted state by one received byte.
	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0] plen;
		int unsigned nxt;
		if (!in_frame) begin
			// The start byte opens a frame; any other byte is dropped.
			if (b == start_reg) begin
				in_frame = 1'b1;
				pos_reg = '0;
				check_reg = CHECK_SEED;
			end
		end else if (pos_reg > 0 && length_reg > 9 && pos_reg == length_reg - 8'd1) begin
			// Checksum slot: the byte is compared, not folded in.
			plen = length_reg - HEADER_LEN;
			close_frame();
			push_word((b == check_reg) ? KIND_GOOD : KIND_BAD, 8'd0, plen, 1'b1);
		end else begin
			check_reg = check_reg ^ b;
			if (pos_reg == POS_LENGTH)
				length_reg = b;
			if (pos_reg == POS_TYPE)
				type_reg = b;
			if (pos_reg == POS_COMMAND)
				command_reg = b;
			nxt = 32'(pos_reg) + 32'd1;
			if (nxt >= MAX_FRAME) begin
				// The frame ran into the size limit.
				close_frame();
				push_word(KIND_OVERRUN, 8'd0, 8'd0, 1'b1);
			end else begin
				if (pos_reg >= POS_PAYLOAD)
					push_word(KIND_PAYLOAD, b, 8'd0, 1'b0);
				pos_reg = nxt[7:0];
			end
		end
	endtask

	// Report one field that differs from its prediction.
	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Sample all channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin : watch
		frame_word_t want;
		if (!arst_n) begin
			start_reg = START_BYTE_RST;
			in_frame = 1'b0;
			pos_reg = '0;
			check_reg = CHECK_SEED;
			length_reg = '0;
			type_reg = '0;
			command_reg = '0;
			expected_words.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected word, expected none, actual kind %0d data %0d",
						$time, kind, data_byte);
				end else begin
					want = expected_words.pop_front();
					pending--;
					check_field("kind", 32'(want.kind), 32'(kind));
					check_field("data_byte", 32'(want.data), 32'(data_byte));
					check_field("msg_type", 32'(want.mtype), 32'(msg_type));
					check_field("command_code", 32'(want.cmd), 32'(command_code));
					check_field("payload_length", 32'(want.plen), 32'(payload_length));
					check_field("last", 32'(want.last), 32'(last));
				end
			end
			if (in_valid && !in_stall)
				deframe_byte(rx_byte);
			if (cfg_we)
				start_reg = cfg_wdata;
		end
	end

endmodule

// ===== test/xor_checked_frame_deframer_unit_test.sv =====
`timescale 1ns / 1ps

// Drives framed byte streams into the deframer under random idling on both
// channels and reports the verdict from the checker's error and pending counts.
module xor_checked_frame_deframer_unit_test;

	import xcfd_pkg::*;

	localparam int unsigned ITEM_TARGET = 1100;
	localparam int unsigned PHASE_ITEMS = 200;
	localparam int unsigned SETTLE = 5;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic [7:0] rx_byte;
	logic       out_stall;
	wire        in_stall;
	wire        out_valid;
	wire  [1:0] kind;
	wire  [7:0] data_byte;
	wire  [7:0] msg_type;
	wire  [7:0] command_code;
	wire  [7:0] payload_length;
	wire        last;
	int         errors;
	int         pending;

	logic [7:0]  start_now;
	bit          calm;
	int unsigned frame_bytes;

	xor_checked_frame_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data_byte(data_byte),
		.msg_type(msg_type),
		.command_code(command_code),
		.payload_length(payload_length),
		.last(last)
	);

	xcfd_frame_checker frame_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data_byte(data_byte),
		.msg_type(msg_type),
		.command_code(command_code),
		.payload_length(payload_length),
		.last(last),
		.errors(errors),
		.pending(pending)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Give up if the run hangs.
	initial begin
		#5_000_000;
		$display("xor_checked_frame_deframer_unit_test NOT OK");
		$finish;
	end

	// Output side: stall for a random number of cycles before each word.
	initial begin : receiver
		int unsigned hold;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			hold = calm ? 0 : $urandom_range(0, 6);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Offer one byte after a random gap and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop sending until every predicted word has come out.
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Change the start byte while the block is quiet.
	task automatic write_start(input logic [7:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		start_now = v;
	endtask

	// Send one frame. Lengths outside the checkable range run on to the size
	// limit. A negative fill gives random content, else every byte after the
	// length and before the checksum is the fill value.
	task automatic send_frame(input int unsigned flen, input bit corrupt, input int fill);
		logic [7:0] sum;
		logic [7:0] b;
		int unsigned body;
		body = (flen >= HEADER_LEN && flen <= MAX_FRAME_DEF) ? flen - 1 : MAX_FRAME_DEF;
		send_byte(start_now);
		sum = CHECK_SEED;
		for (int unsigned i = 0; i < body; i++) begin
			if (i == 0)
				b = flen[7:0];
			else if (fill >= 0)
				b = fill[7:0];
			else if ($urandom_range(0, 15) == 0)
				b = start_now;
			else
				b = 8'($urandom);
			sum = sum ^ b;
			send_byte(b);
		end
		if (body != MAX_FRAME_DEF) begin
			if (corrupt)
				sum = sum ^ 8'($urandom_range(1, 255));
			send_byte(sum);
		end
		frame_bytes += body + 1;
	endtask

	// A byte between frames that the hunt ignores.
	task automatic send_noise();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == start_now)
			b = ~b;
		send_byte(b);
	endtask

	// Stimulus and verdict.
	initial begin : stimulus
		int unsigned phase;
		int unsigned goal;
		int unsigned sel;
		bit paused;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		start_now = START_BYTE_RST;
		calm = 1'b0;
		frame_bytes = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed: a hunted byte, a good frame of zeros, a bad frame of ones.
		send_byte(8'h00);
		send_frame(11, 1'b0, 0);
		send_frame(11, 1'b1, 255);

		// Random phases, each under its own start byte.
		phase = 0;
		while (frame_bytes < ITEM_TARGET) begin
			case (phase)
				0: write_start(8'h00);
				1: write_start(8'hFF);
				2: write_start(START_BYTE_RST);
				default: write_start(8'($urandom));
			endcase
			calm = (phase > 0) && ($urandom_range(0, 3) == 0);
			if (phase == 0) begin
				// Checksum in the last slot, then a short length that overruns.
				send_frame(MAX_FRAME_DEF, 1'b0, -1);
				send_frame($urandom_range(0, 9), 1'b0, -1);
			end
			goal = frame_bytes + PHASE_ITEMS;
			paused = 1'b0;
			while (frame_bytes < goal) begin
				if (!paused && frame_bytes + PHASE_ITEMS / 2 >= goal) begin
					drain();
					paused = 1'b1;
				end
				sel = $urandom_range(0, 31);
				if (sel == 0)
					send_frame($urandom_range(0, 9), 1'b0, -1);
				else if (sel == 1)
					send_frame($urandom_range(254, 255), 1'b0, -1);
				else if (sel == 2)
					send_frame($urandom_range(200, MAX_FRAME_DEF), 1'($urandom_range(0, 1)), -1);
				else
					send_frame($urandom_range(10, 40), sel < 8, -1);
				repeat ($urandom_range(0, 2)) send_noise();
			end
			phase++;
		end

		// Let the last words come out, then wait out the settle time.
		in_valid = 1'b0;
		for (int unsigned w = 0; w < 5000 && pending != 0; w++) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("xor_checked_frame_deframer_unit_test OK");
		else
			$display("xor_checked_frame_deframer_unit_test NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/xcfd_pkg.sv
rtl/xor_checked_frame_deframer_unit.sv
test/xcfd_frame_checker.sv
test/xor_checked_frame_deframer_unit_test.sv
